>>> src/bhq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bhq_pkg;

    localparam int BHQ_CAPACITY = 1024;
    localparam int KEY_W        = 32;
    localparam int TAG_W        = 16;
    localparam int CNT_W        = 11;

    typedef enum logic [1:0] {
        KIND_ENQ   = 2'd0,
        KIND_DEQ   = 2'd1,
        KIND_PEEK  = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic        [TAG_W-1:0] tag;
    } t_entry;

endpackage

`default_nettype wire

>>> src/bhq_channels.sv
`timescale 1ns / 1ps
`default_nettype none

interface bhq_req_if;
    import bhq_pkg::*;

    logic                    valid;
    logic                    ready;
    t_kind                   kind;
    logic signed [KEY_W-1:0] in_key;
    logic        [TAG_W-1:0] in_tag;

    modport source (output valid, output kind, output in_key, output in_tag, input ready);
    modport sink   (input valid, input kind, input in_key, input in_tag, output ready);
endinterface

interface bhq_rsp_if;
    import bhq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] out_key;
    logic        [TAG_W-1:0] out_tag;
    t_status                 status;
    logic        [CNT_W-1:0] count;

    modport source (output valid, output out_key, output out_tag, output status,
                    output count, input ready);
    modport sink   (input valid, input out_key, input out_tag, input status,
                    input count, output ready);
endinterface

`default_nettype wire

>>> src/bhq_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module bhq_mem #(
    parameter int DEPTH = bhq_pkg::BHQ_CAPACITY,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic            i_clk,
    input  wire logic            i_wr_en,
    input  wire logic [AW-1:0]   i_wr_addr,
    input  wire bhq_pkg::t_entry i_wr_data,
    input  wire logic            i_rd_en,
    input  wire logic [AW-1:0]   i_rd_addr,
    output bhq_pkg::t_entry      o_rd_data
);
    import bhq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> src/binary_min_heap_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake      Payload
// i_req     in   valid/ready    kind, in_key, in_tag
// o_rsp     out  valid/ready    out_key, out_tag, status, count
//
// Clear, refused and empty requests go straight to the result; peek and a dequeue of the
// last entry read only the root. Enqueue reads and compares each parent as the entry climbs.
// Other dequeues read the left and then the right child of each level in turn,
// since both children share one memory port.
// Reset clears the count and the sequencer; heap contents need no clearing.
// The result sits in an output register, so a new request is taken while it waits.

module binary_min_heap_queue #(
    parameter int CAPACITY = bhq_pkg::BHQ_CAPACITY
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bhq_req_if.sink    i_req,
    bhq_rsp_if.source  o_rsp
);
    import bhq_pkg::*;

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int XW  = AW + 2;
    localparam int CXW = CW + CNT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_ROOT,
        S_LAST,
        S_DN_CHK,
        S_DN_L,
        S_DN_R,
        S_DN_SEL,
        S_DONE
    } t_state;

    t_state           r_state,      n_state;
    logic [CW-1:0]    r_count,      n_count;
    logic [AW-1:0]    r_pos,        n_pos;
    logic [AW-1:0]    r_idx,        n_idx;
    t_entry           r_ent,        n_ent;
    t_entry           r_cl,         n_cl;
    t_entry           r_child,      n_child;
    logic             r_is_deq,     n_is_deq;
    t_entry           r_res,        n_res;
    t_status          r_res_status, n_res_status;
    logic             r_out_valid,  n_out_valid;
    t_entry           r_out,        n_out;
    t_status          r_out_status, n_out_status;
    logic [CNT_W-1:0] r_out_count,  n_out_count;

    logic                    mem_we;
    logic [AW-1:0]           mem_wa;
    t_entry                  mem_wd;
    logic                    mem_re;
    logic [AW-1:0]           mem_ra;
    t_entry                  rd_data;

    logic signed [KEY_W-1:0] cmp_a;
    logic signed [KEY_W-1:0] cmp_b;
    logic                    cmp_lt;

    logic [XW-1:0]  left_x;
    logic [XW-1:0]  right_x;
    logic [XW-1:0]  cnt_x;
    logic [CW-1:0]  cnt_m1;
    logic [CXW-1:0] cnt_wide;
    logic           req_fire;

    bhq_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_wa),
        .i_wr_data (mem_wd),
        .i_rd_en   (mem_re),
        .i_rd_addr (mem_ra),
        .o_rd_data (rd_data)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && (r_state == S_IDLE);

    assign left_x   = {1'b0, r_pos, 1'b1};
    assign right_x  = left_x + XW'(1);
    assign cnt_x    = XW'(r_count);
    assign cnt_m1   = r_count - CW'(1);
    assign cnt_wide = CXW'(r_count);

    // The one key comparator; its operands are steered by the sequencer state.
    assign cmp_lt = (cmp_a < cmp_b);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_idx        = r_idx;
        n_ent        = r_ent;
        n_cl         = r_cl;
        n_child      = r_child;
        n_is_deq     = r_is_deq;
        n_res        = r_res;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out        = r_out;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        mem_we       = 1'b0;
        mem_wa       = r_pos;
        mem_wd       = r_ent;
        mem_re       = 1'b0;
        mem_ra       = '0;
        cmp_a        = r_ent.key;
        cmp_b        = rd_data.key;

        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_res        = '0;
                    n_res_status = ST_OK;
                    case (i_req.kind)
                        KIND_ENQ: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_res_status = ST_FULL;
                                n_state      = S_DONE;
                            end else begin
                                n_ent.key = i_req.in_key;
                                n_ent.tag = i_req.in_tag;
                                n_pos     = r_count[AW-1:0];
                                n_count   = r_count + CW'(1);
                                n_state   = S_UP_CHK;
                            end
                        end
                        KIND_DEQ, KIND_PEEK: begin
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                                n_state      = S_DONE;
                            end else begin
                                mem_re   = 1'b1;
                                mem_ra   = '0;
                                n_is_deq = (i_req.kind == KIND_DEQ);
                                n_state  = S_ROOT;
                            end
                        end
                        default: begin
                            n_count = '0;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_UP_CHK: begin
                if (r_pos == '0) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    mem_re  = 1'b1;
                    mem_ra  = (r_pos - AW'(1)) >> 1;
                    n_idx   = (r_pos - AW'(1)) >> 1;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                // The new entry climbs only past a parent with a strictly larger key.
                mem_we = 1'b1;
                if (cmp_lt) begin
                    mem_wd  = rd_data;
                    n_pos   = r_idx;
                    n_state = S_UP_CHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ROOT: begin
                n_res = rd_data;
                if (!r_is_deq) begin
                    n_state = S_DONE;
                end else begin
                    n_count = cnt_m1;
                    if (cnt_m1 == '0) begin
                        n_state = S_DONE;
                    end else begin
                        mem_re  = 1'b1;
                        mem_ra  = cnt_m1[AW-1:0];
                        n_state = S_LAST;
                    end
                end
            end
            S_LAST: begin
                n_ent   = rd_data;
                n_pos   = '0;
                n_state = S_DN_CHK;
            end
            S_DN_CHK: begin
                if (left_x >= cnt_x) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    mem_re  = 1'b1;
                    mem_ra  = left_x[AW-1:0];
                    n_idx   = left_x[AW-1:0];
                    n_state = S_DN_L;
                end
            end
            S_DN_L: begin
                n_cl = rd_data;
                if (right_x < cnt_x) begin
                    mem_re  = 1'b1;
                    mem_ra  = right_x[AW-1:0];
                    n_state = S_DN_R;
                end else begin
                    n_child = rd_data;
                    n_state = S_DN_SEL;
                end
            end
            S_DN_R: begin
                // A tie between the children keeps the left one.
                cmp_a = rd_data.key;
                cmp_b = r_cl.key;
                if (cmp_lt) begin
                    n_child = rd_data;
                    n_idx   = r_idx + AW'(1);
                end else begin
                    n_child = r_cl;
                end
                n_state = S_DN_SEL;
            end
            S_DN_SEL: begin
                cmp_a  = r_child.key;
                cmp_b  = r_ent.key;
                mem_we = 1'b1;
                if (cmp_lt) begin
                    mem_wd  = r_child;
                    n_pos   = r_idx;
                    n_state = S_DN_CHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out        = r_res;
                    n_out_status = r_res_status;
                    n_out_count  = cnt_wide[CNT_W-1:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_pos        <= n_pos;
        r_idx        <= n_idx;
        r_ent        <= n_ent;
        r_cl         <= n_cl;
        r_child      <= n_child;
        r_is_deq     <= n_is_deq;
        r_res        <= n_res;
        r_res_status <= n_res_status;
        r_out        <= n_out;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.out_key = r_out.key;
    assign o_rsp.out_tag = r_out.tag;
    assign o_rsp.status  = r_out_status;
    assign o_rsp.count   = r_out_count;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_write_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (XW'(mem_wa) < cnt_x))
        else $error("heap write outside the occupied entries");

    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re && (mem_wa == mem_ra)))
        else $error("heap read and write hit the same entry in one cycle");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_EMPTY)) |-> (r_out_count == '0))
        else $error("empty status reported with a nonzero count");

    a_done_after_climb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_CMP) |=> (r_state == S_UP_CHK || r_state == S_DONE))
        else $error("sift-up left its loop unexpectedly");
`endif

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import bhq_pkg::*;

    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int DRAIN_CYCLES = 80;
    localparam int REPORT_CAP   = 200;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic        [TAG_W-1:0] tag;
        t_status                 status;
        logic        [CNT_W-1:0] count;
    } t_response;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bhq_req_if req_ch ();
    bhq_rsp_if rsp_ch ();

    binary_min_heap_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Mirror of the heap array and its fill level.
    t_entry    mirror_heap [BHQ_CAPACITY];
    int        mirror_count;
    t_response pending_responses[$];
    int        mismatch_count;
    int        send_idle_pct;
    int        rsp_stall_pct;

    function automatic t_response predict_response(input t_kind k,
                                                   input logic signed [KEY_W-1:0] key,
                                                   input logic [TAG_W-1:0] tag);
        t_response r;
        t_entry    tmp;
        int        pos;
        int        parent;
        int        left;
        int        child;
        r = '0;
        r.status = ST_OK;
        case (k)
            KIND_ENQ: begin
                if (mirror_count >= BHQ_CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    pos = mirror_count;
                    mirror_heap[pos] = {key, tag};
                    mirror_count++;
                    while (pos > 0) begin
                        parent = (pos - 1) / 2;
                        if (!($signed(mirror_heap[pos].key) < $signed(mirror_heap[parent].key)))
                            break;
                        tmp = mirror_heap[pos];
                        mirror_heap[pos] = mirror_heap[parent];
                        mirror_heap[parent] = tmp;
                        pos = parent;
                    end
                end
            end
            KIND_DEQ, KIND_PEEK: begin
                if (mirror_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.key = mirror_heap[0].key;
                    r.tag = mirror_heap[0].tag;
                    if (k == KIND_DEQ) begin
                        mirror_count--;
                        mirror_heap[0] = mirror_heap[mirror_count];
                        pos = 0;
                        forever begin
                            left = 2 * pos + 1;
                            if (left >= mirror_count)
                                break;
                            child = left;
                            // On equal children the left one wins.
                            if (left + 1 < mirror_count &&
                                $signed(mirror_heap[left + 1].key) <
                                $signed(mirror_heap[left].key))
                                child = left + 1;
                            if (!($signed(mirror_heap[child].key) < $signed(mirror_heap[pos].key)))
                                break;
                            tmp = mirror_heap[pos];
                            mirror_heap[pos] = mirror_heap[child];
                            mirror_heap[child] = tmp;
                            pos = child;
                        end
                    end
                end
            end
            default: begin
                mirror_count = 0;
            end
        endcase
        r.count = mirror_count[CNT_W-1:0];
        return r;
    endfunction

    function automatic logic signed [KEY_W-1:0] random_key();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5)
            return $urandom;
        if (pick < 8)
            return (int'($urandom_range(6)) - 3) * 65536;
        case ($urandom_range(4))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            3: return 32'shFFFF_FFFF;
            default: return 32'sh0000_0001;
        endcase
    endfunction

    task automatic select_idling(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 61; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 61; end
            default: begin send_idle_pct = 30; rsp_stall_pct = 30; end
        endcase
    endtask

    // Called at a rising edge; returns at the edge where the item was accepted,
    // leaving valid high so the next item can follow without a gap.
    task automatic send_request(input t_kind k, input logic signed [KEY_W-1:0] key,
                                input logic [TAG_W-1:0] tag);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.kind   <= k;
        req_ch.in_key <= key;
        req_ch.in_tag <= tag;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1)
            @(posedge i_clk);
        pending_responses.push_back(predict_response(k, key, tag));
    endtask

    task automatic test_directed_cases();
        select_idling(0);
        send_request(KIND_PEEK, 32'sh1234_5678, 16'hBEEF);
        send_request(KIND_DEQ, 32'sh8000_0000, 16'hFFFF);
        send_request(KIND_ENQ, 32'sh7FFF_FFFF, 16'hFFFF);
        send_request(KIND_ENQ, 32'sh8000_0000, 16'h0000);
        send_request(KIND_ENQ, 32'sh0000_0000, 16'h1234);
        send_request(KIND_ENQ, 32'shFFFF_FFFF, 16'h5555);
        send_request(KIND_ENQ, 32'sh0000_0000, 16'hAAAA);
        send_request(KIND_ENQ, 32'sh0005_0000, 16'h0001);
        send_request(KIND_ENQ, 32'sh0005_0000, 16'h0002);
        send_request(KIND_ENQ, 32'sh0005_0000, 16'h0003);
        send_request(KIND_PEEK, 32'sh0000_0000, 16'h0000);
        repeat (8)
            send_request(KIND_DEQ, 32'shFFFF_FFFF, 16'hFFFF);
        send_request(KIND_DEQ, 32'sh0000_0000, 16'h0000);
        send_request(KIND_ENQ, 32'sh0001_0000, 16'h7777);
        send_request(KIND_ENQ, -32'sh0001_0000, 16'h8888);
        send_request(KIND_CLEAR, 32'shFFFF_FFFF, 16'hFFFF);
        send_request(KIND_PEEK, 32'sh0000_0000, 16'h0000);
        send_request(KIND_CLEAR, 32'sh0000_0000, 16'h0000);
        send_request(KIND_ENQ, 32'sh0000_0007, 16'h00C3);
        send_request(KIND_DEQ, 32'sh0000_0000, 16'h0000);
    endtask

    // Mixed traffic on a small heap, with ties and the odd clear.
    task automatic test_random_mix();
        int    pick;
        t_kind k;
        for (int n = 0; n < 240; n++) begin
            if (n % 60 == 0)
                select_idling(n / 60);
            pick = $urandom_range(99);
            if (pick < 45)
                k = KIND_ENQ;
            else if (pick < 80)
                k = KIND_DEQ;
            else if (pick < 97)
                k = KIND_PEEK;
            else
                k = KIND_CLEAR;
            send_request(k, random_key(), 16'($urandom_range(65535)));
        end
    endtask

    // Grow the heap to capacity and push a few refused enqueues past it.
    task automatic test_fill_to_capacity();
        int n;
        int refused;
        n = 0;
        refused = 0;
        while (refused < 6) begin
            if (n % 256 == 0)
                select_idling(n / 256);
            if ($urandom_range(99) < 5) begin
                send_request(KIND_PEEK, random_key(), 16'($urandom_range(65535)));
            end else begin
                if (mirror_count >= BHQ_CAPACITY)
                    refused++;
                send_request(KIND_ENQ, random_key(), 16'($urandom_range(65535)));
            end
            n++;
        end
    endtask

    // Deep dequeues from a full heap, then clear and reuse.
    task automatic test_drain_and_clear();
        int pick;
        for (int n = 0; n < 160; n++) begin
            if (n % 40 == 0)
                select_idling(n / 40 + 1);
            pick = $urandom_range(99);
            if (pick < 80)
                send_request(KIND_DEQ, random_key(), 16'($urandom_range(65535)));
            else if (pick < 90)
                send_request(KIND_PEEK, random_key(), 16'($urandom_range(65535)));
            else
                send_request(KIND_ENQ, random_key(), 16'($urandom_range(65535)));
        end
        select_idling(0);
        send_request(KIND_CLEAR, random_key(), 16'($urandom_range(65535)));
        send_request(KIND_DEQ, random_key(), 16'($urandom_range(65535)));
        send_request(KIND_ENQ, random_key(), 16'($urandom_range(65535)));
        send_request(KIND_PEEK, random_key(), 16'($urandom_range(65535)));
        send_request(KIND_DEQ, random_key(), 16'($urandom_range(65535)));
    endtask

    always @(posedge i_clk) begin : rsp_monitor
        t_response want;
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_responses.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_CAP)
                    $display("%0t: unexpected result key=%0d tag=%h status=%0d count=%0d",
                             $time, rsp_ch.out_key, rsp_ch.out_tag, rsp_ch.status,
                             rsp_ch.count);
            end else begin
                want = pending_responses.pop_front();
                if (rsp_ch.out_key !== want.key || rsp_ch.out_tag !== want.tag ||
                    rsp_ch.status !== want.status || rsp_ch.count !== want.count) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_CAP)
                        $display({"%0t: mismatch expected key=%0d tag=%h status=%0d ",
                                  "count=%0d, actual key=%0d tag=%h status=%0d count=%0d"},
                                 $time, want.key, want.tag, want.status, want.count,
                                 rsp_ch.out_key, rsp_ch.out_tag, rsp_ch.status,
                                 rsp_ch.count);
                end
            end
        end
    end

    initial begin
        #(LIMIT_CYCLES * 12);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        mismatch_count = 0;
        mirror_count   = 0;
        send_idle_pct  = 0;
        rsp_stall_pct  = 0;
        i_rst_n        <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.kind    <= KIND_ENQ;
        req_ch.in_key  <= '0;
        req_ch.in_tag  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_mix();
        test_fill_to_capacity();
        test_drain_and_clear();

        req_ch.valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
